// ===== rtl/gha_pkg.sv =====
// shared types and constants for the generational handle allocator
package gha_pkg;

   localparam int unsigned SLOTS = 256;
   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned CNT_W = IDX_W + 1;
   localparam logic [31:0] GEN_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      KIND_SPAWN   = 3'd0,
      KIND_DESPAWN = 3'd1,
      KIND_RESET   = 3'd2,
      KIND_RES_HDL = 3'd3,
      KIND_RES_LOC = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_SPAWN_POP,
      ST_SPAWN_CHK,
      ST_SPAWN_RD,
      ST_SPAWN_WR,
      ST_HDL_RD,
      ST_HDL_CHK,
      ST_RST_RD,
      ST_RST_CHK,
      ST_DONE
   } state_type;

   // slot record held in one ram word
   typedef struct packed {
      logic        alive;
      logic        retired;
      logic [31:0] gen;
      logic [31:0] lid;
   } slot_type;

   localparam int unsigned SLOT_W = $bits(slot_type);

endpackage

// ===== rtl/gha_ram.sv =====
// generic single port ram with registered read
module gha_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ===== rtl/generational_handle_allocator.sv =====
// top level: slot table sequencer over slot and free stack memories
//
//  channel | ports                                   | handshake
//  request | req_kind req_local_id req_handle_*      | start high, busy low
//  result  | rsp_ok rsp_out_index rsp_out_generation | rsp_valid one cycle
//          | rsp_out_local_id                        |
//
// despawn and resolve handle read and check one slot; spawn and resolve local
// walk the slot table once (a read and a check per slot in use), and spawn
// then pops the free stack; reset session walks all slots in use. all of
// these go through the single ported slot memory. after reset a clearing
// pass wipes the slot memory with busy high. the receiver
// cannot stall; each result word shows for one cycle.
module generational_handle_allocator
   import gha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_local_id,
   input  logic [7:0]  req_handle_index,
   input  logic [31:0] req_handle_generation,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [7:0]  rsp_out_index,
   output logic [31:0] rsp_out_generation,
   output logic [31:0] rsp_out_local_id
);

   state_type state_ff, state_in;
   logic              clr_ff, clr_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  in_use_ff, in_use_in;
   logic [CNT_W-1:0]  fcnt_ff, fcnt_in;
   logic [2:0]        kind_ff;
   logic [31:0]       lid_ff, gen_ff;
   logic [IDX_W-1:0]  hidx_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              found_ff, found_in;
   logic              rv_ff, rv_in, ok_ff, ok_in;
   logic [7:0]        oi_ff, oi_in;
   logic [31:0]       og_ff, og_in, ol_ff, ol_in;

   logic              s_we, f_we;
   logic [IDX_W-1:0]  s_addr, f_addr;
   slot_type          s_wd, s_rd;
   logic [IDX_W-1:0]  f_wd, f_rd;

   gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot (
      .clock(clock), .wr_en(s_we), .addr(s_addr), .wr_data(s_wd), .rd_data(s_rd)
   );
   gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_free (
      .clock(clock), .wr_en(f_we), .addr(f_addr), .wr_data(f_wd), .rd_data(f_rd)
   );

   logic accept;
   assign busy   = clr_ff || (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // release of a slot record
   slot_type rel;
   always_comb begin
      rel       = s_rd;
      rel.alive = 1'b0;
      rel.lid   = '0;
      if (s_rd.gen == GEN_MAX) rel.retired = 1'b1;
      else                     rel.gen     = s_rd.gen + 32'd1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_SPAWN: begin
                     if (req_local_id == '0) state_in = ST_DONE;
                     else state_in = (in_use_ff == '0) ? ST_SPAWN_POP : ST_SRCH_RD;
                  end
                  KIND_RES_LOC: begin
                     if (req_local_id == '0 || in_use_ff == '0) state_in = ST_DONE;
                     else state_in = ST_SRCH_RD;
                  end
                  KIND_DESPAWN, KIND_RES_HDL: begin
                     if ({1'b0, req_handle_index} >= in_use_ff) state_in = ST_DONE;
                     else state_in = ST_HDL_RD;
                  end
                  KIND_RESET: state_in = (in_use_ff == '0) ? ST_DONE : ST_RST_RD;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SRCH_RD: state_in = ST_SRCH_CHK;
         ST_SRCH_CHK: begin
            if (s_rd.alive && s_rd.lid == lid_ff) begin
               state_in = (kind_ff == KIND_SPAWN) ? ST_DONE : ST_DONE;
            end else if (ptr_ff + 1'b1 >= in_use_ff) begin
               state_in = (kind_ff == KIND_SPAWN) ? ST_SPAWN_POP : ST_DONE;
            end else begin
               state_in = ST_SRCH_RD;
            end
         end
         ST_SPAWN_POP: begin
            if (fcnt_ff == '0) begin
               state_in = (in_use_ff >= CNT_W'(SLOTS)) ? ST_DONE : ST_SPAWN_RD;
            end else begin
               state_in = ST_SPAWN_CHK;
            end
         end
         // free stack entry is out; fetch its slot
         ST_SPAWN_CHK: state_in = ST_SPAWN_RD;
         ST_SPAWN_RD:  state_in = ST_SPAWN_WR;
         ST_SPAWN_WR: begin
            if (found_ff && s_rd.retired) state_in = ST_SPAWN_POP;
            else                          state_in = ST_DONE;
         end
         ST_HDL_RD:  state_in = ST_HDL_CHK;
         ST_HDL_CHK: state_in = ST_DONE;
         ST_RST_RD:  state_in = ST_RST_CHK;
         ST_RST_CHK: state_in = (ptr_ff + 1'b1 >= in_use_ff) ? ST_DONE : ST_RST_RD;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in = clr_ff; ptr_in = ptr_ff; in_use_in = in_use_ff; fcnt_in = fcnt_ff;
      idx_in = idx_ff; found_in = found_ff;
      rv_in = 1'b0; ok_in = ok_ff; oi_in = oi_ff; og_in = og_ff; ol_in = ol_ff;
      s_we = 1'b0; s_addr = ptr_ff[IDX_W-1:0]; s_wd = rel;
      f_we = 1'b0; f_addr = '0; f_wd = ptr_ff[IDX_W-1:0];
      if (clr_ff) begin
         s_we = 1'b1; s_wd = '0;
         ptr_in = ptr_ff + 1'b1;
         if (ptr_ff == CNT_W'(SLOTS - 1)) begin
            clr_in = 1'b0; ptr_in = '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               ptr_in = '0; found_in = 1'b0;
               ok_in = 1'b0; oi_in = '0; og_in = '0; ol_in = '0;
               if (accept && req_kind == KIND_RESET) fcnt_in = '0;
            end
            ST_SRCH_RD: s_addr = ptr_ff[IDX_W-1:0];
            ST_SRCH_CHK: begin
               if (s_rd.alive && s_rd.lid == lid_ff) begin
                  if (kind_ff == KIND_RES_LOC) begin
                     ok_in = 1'b1; oi_in = 8'(ptr_ff);
                     og_in = s_rd.gen; ol_in = lid_ff;
                  end
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
            ST_SPAWN_POP: begin
               found_in = 1'b0;
               if (fcnt_ff != '0) begin
                  f_addr  = IDX_W'(fcnt_ff - 1'b1);
                  fcnt_in = fcnt_ff - 1'b1;
                  found_in = 1'b1;
               end else begin
                  idx_in = in_use_ff[IDX_W-1:0];
               end
            end
            ST_SPAWN_CHK: idx_in = f_rd;
            ST_SPAWN_RD:  s_addr = idx_ff;
            ST_SPAWN_WR: begin
               s_addr = idx_ff;
               if (!(found_ff && s_rd.retired)) begin
                  s_we = 1'b1;
                  s_wd = s_rd; s_wd.alive = 1'b1; s_wd.lid = lid_ff;
                  if (!found_ff) begin
                     in_use_in = in_use_ff + 1'b1;
                     s_wd = '{alive: 1'b1, retired: 1'b0, gen: '0, lid: lid_ff};
                  end
                  ok_in = 1'b1; oi_in = 8'(idx_ff);
                  og_in = found_ff ? s_rd.gen : 32'd0; ol_in = lid_ff;
               end
            end
            ST_HDL_RD: s_addr = hidx_ff;
            ST_HDL_CHK: begin
               s_addr = hidx_ff;
               if (s_rd.alive && s_rd.gen == gen_ff) begin
                  ok_in = 1'b1;
                  if (kind_ff == KIND_DESPAWN) begin
                     s_we = 1'b1;
                     if (s_rd.gen != GEN_MAX && fcnt_ff < CNT_W'(SLOTS)) begin
                        f_we = 1'b1; f_addr = IDX_W'(fcnt_ff); f_wd = hidx_ff;
                        fcnt_in = fcnt_ff + 1'b1;
                     end
                  end else begin
                     oi_in = 8'(hidx_ff); og_in = gen_ff; ol_in = s_rd.lid;
                  end
               end
            end
            ST_RST_RD: s_addr = ptr_ff[IDX_W-1:0];
            ST_RST_CHK: begin
               s_addr = ptr_ff[IDX_W-1:0];
               ptr_in = ptr_ff + 1'b1;
               if (s_rd.alive) s_we = 1'b1;
               if ((s_rd.alive && s_rd.gen != GEN_MAX) || (!s_rd.alive && !s_rd.retired))
               begin
                  if (fcnt_ff < CNT_W'(SLOTS)) begin
                     f_we = 1'b1; f_addr = IDX_W'(fcnt_ff);
                     fcnt_in = fcnt_ff + 1'b1;
                  end
               end
               if (ptr_ff + 1'b1 >= in_use_ff) ok_in = 1'b1;
            end
            ST_DONE: rv_in = 1'b1;
            default: ;
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; clr_ff <= 1'b1; ptr_ff <= '0;
         in_use_ff <= '0; fcnt_ff <= '0; rv_ff <= 1'b0; found_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; ptr_ff <= ptr_in;
         in_use_ff <= in_use_in; fcnt_ff <= fcnt_in; rv_ff <= rv_in;
         found_ff <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind; lid_ff <= req_local_id;
         hidx_ff <= req_handle_index; gen_ff <= req_handle_generation;
      end
      idx_ff <= idx_in;
      ok_ff <= (state_ff == ST_IDLE && accept && req_kind == KIND_RESET && in_use_ff == '0)
               ? 1'b1 : ok_in;
      oi_ff <= oi_in; og_ff <= og_in; ol_ff <= ol_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_ok             = ok_ff;
   assign rsp_out_index      = oi_ff;
   assign rsp_out_generation = og_ff;
   assign rsp_out_local_id   = ol_ff;

endmodule

// ===== tb/generational_handle_allocator_tb.sv =====
// self-checking testbench for the generational handle allocator
`timescale 1ns / 100ps

module generational_handle_allocator_tb
   import gha_pkg::*;
();

   // request word and its expected response
   typedef struct {
      logic [2:0]  kind;
      logic [31:0] lid;
      logic [7:0]  hidx;
      logic [31:0] hgen;
   } req_word_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  index;
      logic [31:0] gen;
      logic [31:0] lid;
   } rsp_word_type;

   // directed row: request plus optional typed-in response
   typedef struct {
      req_word_type req;
      bit           fixed;
      rsp_word_type rsp;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_kind = '0;
   logic [31:0] req_local_id = '0;
   logic [7:0]  req_handle_index = '0;
   logic [31:0] req_handle_generation = '0;
   logic        rsp_valid;
   logic        rsp_ok;
   logic [7:0]  rsp_out_index;
   logic [31:0] rsp_out_generation;
   logic [31:0] rsp_out_local_id;

   int unsigned error_count = 0;
   bit          quiet_tail = 0;

   // predictor copy of the slot table
   bit          tbl_alive [SLOTS];
   bit          tbl_retired [SLOTS];
   logic [31:0] tbl_gen [SLOTS];
   logic [31:0] tbl_lid [SLOTS];
   int unsigned tbl_in_use;
   int unsigned free_idx [SLOTS];
   int unsigned free_top;

   rsp_word_type pending_rsp [$];
   logic [31:0]  bound_ids [$];
   row_type      rows [$];

   generational_handle_allocator dut (.*);

   always #5 clock = ~clock;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   function automatic void add_row(input req_word_type r, input bit fixed,
                                   input rsp_word_type w);
      row_type row;
      row.req = r;
      row.fixed = fixed;
      row.rsp = w;
      rows.insert(rows.size(), row);
   endfunction

   function automatic void free_push(input int unsigned idx);
      if (free_top < SLOTS) begin
         free_idx[free_top] = idx;
         free_top++;
      end
   endfunction

   function automatic void slot_release(input int unsigned idx);
      tbl_alive[idx] = 0;
      tbl_lid[idx] = '0;
      if (tbl_gen[idx] == GEN_MAX) tbl_retired[idx] = 1;
      else begin
         tbl_gen[idx]++;
         free_push(idx);
      end
   endfunction

   function automatic int lookup_local(input logic [31:0] id);
      if (id == 0) return -1;
      for (int i = 0; i < tbl_in_use; i++)
         if (tbl_alive[i] && tbl_lid[i] == id) return i;
      return -1;
   endfunction

   function automatic bit handle_live(input logic [7:0] idx, input logic [31:0] gen);
      return idx < tbl_in_use && tbl_alive[idx] && tbl_gen[idx] == gen;
   endfunction

   // compute the response a request causes and update the table
   function automatic rsp_word_type allocate_step(input req_word_type r);
      rsp_word_type o;
      int           idx;
      o = '{default: '0};
      case (r.kind)
         KIND_SPAWN: begin
            if (r.lid != 0 && lookup_local(r.lid) < 0) begin
               while (free_top > 0 && tbl_retired[free_idx[free_top-1]]) free_top--;
               idx = -1;
               if (free_top == 0) begin
                  if (tbl_in_use < SLOTS) begin
                     idx = tbl_in_use;
                     tbl_in_use++;
                  end
               end else begin
                  free_top--;
                  idx = free_idx[free_top];
               end
               if (idx >= 0) begin
                  tbl_alive[idx] = 1;
                  tbl_lid[idx] = r.lid;
                  o = '{1'b1, idx[7:0], tbl_gen[idx], r.lid};
               end
            end
         end
         KIND_DESPAWN: begin
            if (handle_live(r.hidx, r.hgen)) begin
               slot_release(r.hidx);
               o.ok = 1;
            end
         end
         KIND_RESET: begin
            free_top = 0;
            for (int i = 0; i < tbl_in_use; i++) begin
               if (tbl_alive[i]) slot_release(i);
               else if (!tbl_retired[i]) free_push(i);
            end
            o.ok = 1;
         end
         KIND_RES_HDL: begin
            if (handle_live(r.hidx, r.hgen))
               o = '{1'b1, r.hidx, r.hgen, tbl_lid[r.hidx]};
         end
         KIND_RES_LOC: begin
            idx = lookup_local(r.lid);
            if (idx >= 0) o = '{1'b1, idx[7:0], tbl_gen[idx], r.lid};
         end
         default: ;
      endcase
      return o;
   endfunction

   // random sender gap length
   function automatic int unsigned sender_gap();
      if (!quiet_tail && $urandom_range(0, 3) == 0) return $urandom_range(1, 12);
      return 0;
   endfunction

   // present one request word and wait until it is taken
   task automatic send_word(input req_word_type r, input bit fixed, input rsp_word_type want);
      rsp_word_type pred;
      int unsigned  gap;
      gap = sender_gap();
      @(negedge clock);
      // start stays low through an idle burst
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind <= r.kind;
      req_local_id <= r.lid;
      req_handle_index <= r.hidx;
      req_handle_generation <= r.hgen;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pred = allocate_step(r);
      if (fixed && pred != want) report("typed row vs predictor", pred.gen, want.gen);
      pending_rsp.insert(pending_rsp.size(), pred);
   endtask

   // resolve slot zero at the highest generation
   task automatic age_slot_zero();
      req_word_type r;
      rsp_word_type z;
      z = '{default: '0};
      // a live slot zero sits far below the generation limit here
      r = '{KIND_RES_HDL, 32'h0, 8'h0, GEN_MAX};
      send_word(r, 0, z);
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) report("unexpected response", {31'b0, rsp_ok}, 32'h0);
         else begin
            want = pending_rsp.pop_front();
            if (rsp_ok !== want.ok) report("ok", {31'b0, rsp_ok}, {31'b0, want.ok});
            if (rsp_out_index !== want.index)
               report("out_index", {24'b0, rsp_out_index}, {24'b0, want.index});
            if (rsp_out_generation !== want.gen)
               report("out_generation", rsp_out_generation, want.gen);
            if (rsp_out_local_id !== want.lid)
               report("out_local_id", rsp_out_local_id, want.lid);
         end
      end
   end

   // run limit
   initial begin
      #20ms;
      $display("generational_handle_allocator_tb: FAIL");
      $finish;
   end

   initial begin
      req_word_type r;
      rsp_word_type z;
      int           pick, waited;
      z = '{default: '0};
      tbl_alive = '{default: 0};
      tbl_retired = '{default: 0};
      tbl_gen = '{default: '0};
      tbl_lid = '{default: '0};
      tbl_in_use = 0;
      free_top = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows
      add_row('{KIND_RES_LOC, 32'h0, 8'h0, 32'h0}, 1, z);
      add_row('{KIND_RES_HDL, 32'h0, 8'h0, 32'h0}, 1, z);
      add_row('{KIND_DESPAWN, 32'h0, 8'hFF, GEN_MAX}, 1, z);
      add_row('{KIND_SPAWN, 32'h0, 8'h0, 32'h0}, 1, z);
      add_row('{KIND_SPAWN, 32'hFFFF_FFFF, 8'h0, 32'h0}, 1,
              '{1'b1, 8'h0, 32'h0, 32'hFFFF_FFFF});
      add_row('{KIND_SPAWN, 32'hFFFF_FFFF, 8'h0, 32'h0}, 1, z);
      add_row('{KIND_SPAWN, 32'h1, 8'h0, 32'h0}, 1, '{1'b1, 8'h1, 32'h0, 32'h1});
      add_row('{KIND_RES_LOC, 32'h1, 8'h0, 32'h0}, 0, z);
      add_row('{KIND_RES_HDL, 32'h0, 8'h0, 32'h0}, 0, z);
      add_row('{KIND_RES_HDL, 32'h0, 8'h0, 32'h1}, 1, z);
      add_row('{KIND_RES_HDL, 32'h0, 8'h2, 32'h0}, 1, z);
      add_row('{KIND_DESPAWN, 32'h0, 8'h0, 32'h0}, 1, '{1'b1, 8'h0, 32'h0, 32'h0});
      add_row('{KIND_DESPAWN, 32'h0, 8'h0, 32'h0}, 1, z);
      add_row('{KIND_SPAWN, 32'h5A5A_0001, 8'h0, 32'h0}, 0, z);
      add_row('{3'd5, 32'hFFFF_FFFF, 8'hFF, GEN_MAX}, 1, z);
      add_row('{3'd6, 32'h1, 8'h1, 32'h0}, 1, z);
      add_row('{3'd7, 32'h0, 8'h0, 32'h0}, 1, z);
      add_row('{KIND_RESET, 32'h0, 8'h0, 32'h0}, 1, '{1'b1, 8'h0, 32'h0, 32'h0});
      add_row('{KIND_SPAWN, 32'h2, 8'h0, 32'h0}, 0, z);
      add_row('{KIND_SPAWN, 32'h3, 8'h0, 32'h0}, 0, z);
      add_row('{KIND_RES_LOC, 32'h3, 8'h0, 32'h0}, 0, z);
      foreach (rows[i]) send_word(rows[i].req, rows[i].fixed, rows[i].rsp);
      age_slot_zero();

      // random part: mostly well-formed ops on live handles and known ids
      for (int n = 0; n < 650; n++) begin
         if (n > 590) quiet_tail = 1;
         r.kind = KIND_SPAWN;
         r.lid = $urandom();
         r.hidx = 8'($urandom());
         r.hgen = $urandom();
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            r.kind = KIND_SPAWN;
            if ($urandom_range(0, 4) == 0 && bound_ids.size() > 0)
               r.lid = bound_ids[$urandom_range(0, bound_ids.size() - 1)];
            else if ($urandom_range(0, 19) == 0) r.lid = '0;
            bound_ids.insert(bound_ids.size(), r.lid);
         end else if (pick < 80) begin
            r.kind = (pick < 60) ? KIND_DESPAWN : KIND_RES_HDL;
            if (tbl_in_use > 0 && $urandom_range(0, 5) != 0) begin
               r.hidx = 8'($urandom_range(0, tbl_in_use - 1));
               r.hgen = tbl_gen[r.hidx];
               if ($urandom_range(0, 7) == 0) r.hgen ^= 32'h1 << $urandom_range(0, 31);
            end
         end else if (pick < 93) begin
            r.kind = KIND_RES_LOC;
            if (bound_ids.size() > 0 && $urandom_range(0, 3) != 0)
               r.lid = bound_ids[$urandom_range(0, bound_ids.size() - 1)];
         end else if (pick < 97) r.kind = KIND_RESET;
         else r.kind = 3'($urandom_range(5, 7));
         send_word(r, 0, z);
      end
      @(negedge clock);
      start <= 1'b0;

      // drain
      waited = 0;
      while (pending_rsp.size() > 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (600) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("generational_handle_allocator_tb: PASS");
      else
         $display("generational_handle_allocator_tb: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gha_pkg.sv
rtl/gha_ram.sv
rtl/generational_handle_allocator.sv
tb/generational_handle_allocator_tb.sv
